FILE: rtl/core/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// shared constants and register codes of the trimmed median window filter
// ----------------------------------------------------------------------------
package tmwf_pkg;

    localparam int DEF_MAX_WINDOW = 7;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int WS_W   = 3;
    localparam int TRIM_W = 5;
    localparam int DIM_W  = 11;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [WS_W-1:0]   RST_WINDOW_SIZE = 3'd3;
    localparam logic [TRIM_W-1:0] RST_TRIM        = 5'd0;
    localparam logic [DIM_W-1:0]  RST_WIDTH       = 11'd640;
    localparam logic [DIM_W-1:0]  RST_HEIGHT      = 11'd480;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_TRIM        = 2'd1,
        REG_WIDTH       = 2'd2,
        REG_HEIGHT      = 2'd3
    } reg_idx_t;

endpackage

FILE: rtl/core/trimmed_median_window_filter_top.sv
// ----------------------------------------------------------------------------
// trimmed_median_window_filter_top
// alpha-trimmed mean around the median of a square window, raster streaming
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_ channel (tuser high marks a fill item
// that only paces out the outputs left after the last pixel of a frame). Each
// item runs through one sequencer: a stored pixel takes a serial row-modulo
// pass and a write state, then the MUL_A and MUL_B states decide whether an
// output is due. A due output adds a start state, a serial modulo, one
// line-buffer read per window element (from the single read port), a settle
// state, a drain through the sorted insertion array and a division in the
// shared restoring divider, then the emit state, which waits for the output
// register to empty. A new item is accepted only in the idle state, after the
// previous one is through. The line buffer is not cleared after reset; a
// window that touches a never written position returns an undefined value.
// Configuration is written through the APB-style port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module trimmed_median_window_filter_top #(
    parameter int MAX_WINDOW = tmwf_pkg::DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = tmwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tmwf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // pixel_in
    input  logic                        s_tuser,   // fill
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // pixel_out
    output logic                        m_tlast,   // frame_end
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmwf_pkg::APB_AW-1:0] paddr,
    input  logic [tmwf_pkg::APB_DW-1:0] pwdata,
    output logic [tmwf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int NMAX   = MAX_WINDOW * MAX_WINDOW;
    localparam int SWC    = $clog2(MAX_WINDOW + 1);
    localparam int SW     = (SWC > 3) ? SWC : 3;
    localparam int NW     = $clog2(NMAX + 1);
    localparam int TW     = (NW > 5) ? NW : 5;
    localparam int SUMW   = $clog2(NMAX * 255 + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int DVW    = (SUMW > RW) ? SUMW : RW;
    localparam int DCW    = $clog2(DVW + 1);
    localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SLW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RSW    = RW + 2;
    localparam int CSW    = CW + 2;
    localparam int PW     = RW + XW + 1;
    localparam int GWW    = (tmwf_pkg::DIM_W > XW) ? tmwf_pkg::DIM_W + 1 : XW + 1;
    localparam int GHW    = (tmwf_pkg::DIM_W > RW) ? tmwf_pkg::DIM_W + 1 : RW + 1;
    localparam int S_TOP  = (MAX_WINDOW - 1) | 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_IN,
        ST_WRITE,
        ST_MUL_A,
        ST_MUL_B,
        ST_START,
        ST_MOD_ROW,
        ST_GATHER,
        ST_SETTLE,
        ST_DRAIN,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    function automatic logic [RW-1:0] row_clamp(input logic signed [RSW-1:0] u,
                                                 input logic [RW-1:0] hi);
        logic [RW-1:0] r;
        if (u < 0)
            r = '0;
        else if (u > signed'({2'b00, hi}))
            r = hi;
        else
            r = u[RW-1:0];
        return r;
    endfunction

    function automatic logic [CW-1:0] col_clamp(input logic signed [CSW-1:0] u,
                                                 input logic [CW-1:0] hi);
        logic [CW-1:0] c;
        if (u < 0)
            c = '0;
        else if (u > signed'({2'b00, hi}))
            c = hi;
        else
            c = u[CW-1:0];
        return c;
    endfunction

    // configuration registers
    logic [tmwf_pkg::WS_W-1:0]   ws_reg;
    logic [tmwf_pkg::TRIM_W-1:0] trim_reg;
    logic [tmwf_pkg::DIM_W-1:0]  iw_reg;
    logic [tmwf_pkg::DIM_W-1:0]  ih_reg;
    tmwf_pkg::reg_idx_t          cfg_idx;
    logic                        cfg_we;

    // effective settings
    logic [SW-1:0]  s_raw;
    logic [SW-1:0]  s_eff;
    logic [SW-1:0]  p_eff;
    logic [NW-1:0]  n_eff;
    logic [NW-1:0]  half_eff;
    logic [NW-1:0]  t_eff;
    logic [NW-1:0]  lo_eff;
    logic [NW-1:0]  hi_eff;
    logic [NW-1:0]  den_eff;
    logic [XW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;

    // sequencer and counters
    state_t             state_reg;
    logic [7:0]         pix_reg;
    logic [RW-1:0]      irow_reg;
    logic [CW-1:0]      icol_reg;
    logic [RW-1:0]      orow_reg;
    logic [CW-1:0]      ocol_reg;
    logic               in_done_reg;
    logic [SLW-1:0]     wslot_reg;
    logic [SLW-1:0]     slot_reg;
    logic [PW-1:0]      prod_a_reg;
    logic signed [RSW-1:0] u_r_reg;
    logic signed [CSW-1:0] u_c_reg;
    logic signed [CSW-1:0] u_c0_reg;
    logic [SW-1:0]      dx_reg;
    logic [SW-1:0]      dy_reg;
    logic [NW-1:0]      drain_idx_reg;
    logic [SUMW-1:0]    sum_reg;
    logic [SUMW-1:0]    sum_next;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tlast_reg;

    // shared restoring divider
    logic [DVW-1:0]     div_quo_reg;
    logic [NW-1:0]      div_rem_reg;
    logic [NW-1:0]      div_den_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [NW:0]        div_trial;
    logic [DVW-1:0]     div_quo_next;
    logic [NW-1:0]      div_rem_next;
    logic               div_last;

    // readiness multiplier
    logic [RW:0]        nr_full;
    logic [RW-1:0]      nr;
    logic [CW:0]        nc_full;
    logic [CW-1:0]      nc;
    logic [RW-1:0]      mul_x;
    logic [CW-1:0]      mul_add;
    logic [PW-1:0]      mul_res;
    logic               out_due;

    // window walk
    logic signed [RSW-1:0] u_r_inc;
    logic [RW-1:0]      r_cur;
    logic [RW-1:0]      r_inc;
    logic signed [RSW-1:0] u_r_start;
    logic signed [CSW-1:0] u_c_start;

    // line buffer
    logic [7:0]         row_mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         rd_data_reg;
    logic               rd_valid_reg;

    // sorted insertion array
    logic [7:0]         sort_reg [NMAX];
    logic [NW-1:0]      sort_cnt_reg;
    logic [NMAX-1:0]    gt;
    logic [7:0]         ins [NMAX];

    // counter steps
    logic [CW:0]        icol_inc;
    logic [RW:0]        irow_inc;
    logic [CW:0]        ocol_inc;
    logic [RW:0]        orow_inc;

    assign cfg_idx = tmwf_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            tmwf_pkg::REG_WINDOW_SIZE: prdata = tmwf_pkg::APB_DW'(ws_reg);
            tmwf_pkg::REG_TRIM:        prdata = tmwf_pkg::APB_DW'(trim_reg);
            tmwf_pkg::REG_WIDTH:       prdata = tmwf_pkg::APB_DW'(iw_reg);
            tmwf_pkg::REG_HEIGHT:      prdata = tmwf_pkg::APB_DW'(ih_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= tmwf_pkg::RST_WINDOW_SIZE;
            trim_reg <= tmwf_pkg::RST_TRIM;
            iw_reg   <= tmwf_pkg::RST_WIDTH;
            ih_reg   <= tmwf_pkg::RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tmwf_pkg::REG_WINDOW_SIZE: ws_reg <= pwdata[tmwf_pkg::WS_W-1:0];
                tmwf_pkg::REG_TRIM:        trim_reg <= pwdata[tmwf_pkg::TRIM_W-1:0];
                tmwf_pkg::REG_WIDTH:       iw_reg <= pwdata[tmwf_pkg::DIM_W-1:0];
                tmwf_pkg::REG_HEIGHT:      ih_reg <= pwdata[tmwf_pkg::DIM_W-1:0];
                default:                   ws_reg <= ws_reg;
            endcase
        end
    end

    // effective window, trim and frame size
    always_comb
    begin
        s_raw    = SW'({ws_reg[2:1], 1'b1});
        s_eff    = (s_raw > SW'(S_TOP)) ? SW'(S_TOP) : s_raw;
        p_eff    = s_eff >> 1;
        n_eff    = NW'(NW'(s_eff) * NW'(s_eff));
        half_eff = n_eff >> 1;
        t_eff    = (TW'(trim_reg) > TW'(half_eff)) ? half_eff : NW'(trim_reg);
        lo_eff   = half_eff - t_eff;
        hi_eff   = half_eff + t_eff;
        den_eff  = NW'({t_eff, 1'b1});
        if (iw_reg == '0)
            w_eff = XW'(1);
        else if (GWW'(iw_reg) > GWW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(iw_reg);
        if (ih_reg == '0)
            h_eff = RW'(1);
        else if (GHW'(ih_reg) > GHW'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(ih_reg);
        w_last = CW'(w_eff - XW'(1));
        h_last = h_eff - RW'(1);
    end

    // one restoring step per cycle
    always_comb
    begin
        div_trial    = {div_rem_reg, div_quo_reg[DVW-1]};
        div_last     = (div_cnt_reg == DCW'(1));
        if (div_trial >= {1'b0, div_den_reg})
        begin
            div_rem_next = NW'(div_trial - {1'b0, div_den_reg});
            div_quo_next = {div_quo_reg[DVW-2:0], 1'b1};
        end
        else
        begin
            div_rem_next = div_trial[NW-1:0];
            div_quo_next = {div_quo_reg[DVW-2:0], 1'b0};
        end
    end

    // raster position products for the output-due test
    always_comb
    begin
        nr_full = RW'(orow_reg) + (RW+1)'(p_eff);
        nr      = (nr_full > (RW+1)'(h_last)) ? h_last : nr_full[RW-1:0];
        nc_full = (CW+1)'(ocol_reg) + (CW+1)'(p_eff);
        nc      = (nc_full > (CW+1)'(w_last)) ? w_last : nc_full[CW-1:0];
        mul_x   = (state_reg == ST_MUL_A) ? irow_reg : nr;
        mul_add = (state_reg == ST_MUL_A) ? icol_reg : nc;
        mul_res = PW'(PW'(mul_x) * PW'(w_eff)) + PW'(mul_add);
        out_due = in_done_reg || (prod_a_reg > mul_res);
    end

    always_comb
    begin
        u_r_inc   = u_r_reg + RSW'(1);
        r_cur     = row_clamp(u_r_reg, h_last);
        r_inc     = row_clamp(u_r_inc, h_last);
        u_r_start = signed'(RSW'(orow_reg)) - signed'(RSW'(p_eff));
        u_c_start = signed'(CSW'(ocol_reg)) - signed'(CSW'(p_eff));
        mem_we    = (state_reg == ST_WRITE);
        mem_waddr = AW'(AW'(wslot_reg) * AW'(MAX_WIDTH)) + AW'(icol_reg);
        mem_raddr = AW'(AW'(slot_reg) * AW'(MAX_WIDTH)) + AW'(col_clamp(u_c_reg, w_last));
        icol_inc  = (CW+1)'(icol_reg) + (CW+1)'(1);
        irow_inc  = (RW+1)'(irow_reg) + (RW+1)'(1);
        ocol_inc  = (CW+1)'(ocol_reg) + (CW+1)'(1);
        orow_inc  = (RW+1)'(orow_reg) + (RW+1)'(1);
        sum_next  = (drain_idx_reg >= lo_eff) ? sum_reg + SUMW'(sort_reg[0]) : sum_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_waddr] <= pix_reg;
        rd_data_reg <= row_mem[mem_raddr];
    end

    // insertion position: every valid entry above the new value moves up one
    always_comb
    begin
        for (int k = 0; k < NMAX; k++)
            gt[k] = (NW'(k) >= sort_cnt_reg) || (sort_reg[k] > rd_data_reg);
        for (int k = 0; k < NMAX; k++)
        begin
            if (!gt[k])
                ins[k] = sort_reg[k];
            else if (k > 0 && gt[(k > 0) ? k - 1 : 0])
                ins[k] = sort_reg[(k > 0) ? k - 1 : 0];
            else
                ins[k] = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            for (int k = 0; k < NMAX; k++)
                sort_reg[k] <= ins[k];
        end
        else if (state_reg == ST_DRAIN)
        begin
            for (int k = 0; k < NMAX - 1; k++)
                sort_reg[k] <= sort_reg[k + 1];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            pix_reg  <= s_tdata;
        if (state_reg == ST_MUL_A)
            prod_a_reg <= mul_res;
        if (state_reg == ST_MOD_IN && div_last)
            wslot_reg <= SLW'(div_rem_next);
        if (state_reg == ST_START)
        begin
            u_c0_reg <= u_c_start;
        end
        if (state_reg == ST_START)
            sum_reg <= '0;
        else if (state_reg == ST_DRAIN)
            sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            irow_reg      <= '0;
            icol_reg      <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            in_done_reg   <= 1'b0;
            slot_reg      <= '0;
            u_r_reg       <= '0;
            u_c_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            drain_idx_reg <= '0;
            div_quo_reg   <= '0;
            div_rem_reg   <= '0;
            div_den_reg   <= '0;
            div_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            sort_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_GATHER);
            if (rd_valid_reg)
                sort_cnt_reg <= sort_cnt_reg + NW'(1);
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_MOD_IN || state_reg == ST_MOD_ROW || state_reg == ST_DIVIDE)
            begin
                div_quo_reg <= div_quo_next;
                div_rem_reg <= div_rem_next;
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (!s_tuser && !in_done_reg)
                        begin
                            div_quo_reg <= DVW'(irow_reg);
                            div_rem_reg <= '0;
                            div_den_reg <= NW'(s_eff);
                            div_cnt_reg <= DCW'(DVW);
                            state_reg   <= ST_MOD_IN;
                        end
                        else
                            state_reg <= ST_MUL_A;
                    end
                end
                ST_MOD_IN:
                begin
                    if (div_last)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (icol_inc >= (CW+1)'(w_eff))
                    begin
                        icol_reg <= '0;
                        irow_reg <= irow_inc[RW-1:0];
                        if (irow_inc >= (RW+1)'(h_eff))
                            in_done_reg <= 1'b1;
                    end
                    else
                        icol_reg <= icol_inc[CW-1:0];
                    state_reg <= ST_MUL_A;
                end
                ST_MUL_A:
                begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    state_reg <= out_due ? ST_START : ST_IDLE;
                end
                ST_START:
                begin
                    u_r_reg      <= u_r_start;
                    u_c_reg      <= u_c_start;
                    sort_cnt_reg <= '0;
                    div_quo_reg  <= DVW'(row_clamp(u_r_start, h_last));
                    div_rem_reg  <= '0;
                    div_den_reg  <= NW'(s_eff);
                    div_cnt_reg  <= DCW'(DVW);
                    state_reg    <= ST_MOD_ROW;
                end
                ST_MOD_ROW:
                begin
                    if (div_last)
                    begin
                        slot_reg  <= SLW'(div_rem_next);
                        dx_reg    <= '0;
                        dy_reg    <= '0;
                        state_reg <= ST_GATHER;
                    end
                end
                ST_GATHER:
                begin
                    if (dx_reg == s_eff - SW'(1))
                    begin
                        dx_reg  <= '0;
                        u_c_reg <= u_c0_reg;
                        u_r_reg <= u_r_inc;
                        if (r_inc != r_cur)
                            slot_reg <= (SW'(slot_reg) == s_eff - SW'(1)) ? '0
                                                                          : slot_reg + SLW'(1);
                        if (dy_reg == s_eff - SW'(1))
                            state_reg <= ST_SETTLE;
                        else
                            dy_reg <= dy_reg + SW'(1);
                    end
                    else
                    begin
                        dx_reg  <= dx_reg + SW'(1);
                        u_c_reg <= u_c_reg + CSW'(1);
                    end
                end
                ST_SETTLE:
                begin
                    drain_idx_reg <= '0;
                    state_reg     <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (drain_idx_reg == hi_eff)
                    begin
                        div_quo_reg <= DVW'(sum_next);
                        div_rem_reg <= '0;
                        div_den_reg <= den_eff;
                        div_cnt_reg <= DCW'(DVW);
                        state_reg   <= ST_DIVIDE;
                    end
                    else
                        drain_idx_reg <= drain_idx_reg + NW'(1);
                end
                ST_DIVIDE:
                begin
                    if (div_last)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= div_quo_reg[7:0];
                        m_tlast_reg  <= 1'b0;
                        state_reg    <= ST_IDLE;
                        if (ocol_inc >= (CW+1)'(w_eff))
                        begin
                            ocol_reg <= '0;
                            if (orow_inc >= (RW+1)'(h_eff))
                            begin
                                m_tlast_reg <= 1'b1;
                                orow_reg    <= '0;
                                irow_reg    <= '0;
                                icol_reg    <= '0;
                                in_done_reg <= 1'b0;
                            end
                            else
                                orow_reg <= orow_inc[RW-1:0];
                        end
                        else
                            ocol_reg <= ocol_inc[CW-1:0];
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_sort_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sort_cnt_reg <= NW'(NMAX))
        else $error("sort array over-filled");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (drain_idx_reg <= hi_eff))
        else $error("drain index past upper trim bound");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> (SW'(slot_reg) < s_eff))
        else $error("line slot out of window range");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output register busy");
`endif

endmodule
